// File: design/lfrp_pkg.sv
package lfrp_pkg;

   localparam int USER_COUNT_DEF = 4096;
   localparam int ITEM_COUNT_DEF = 4096;
   localparam int LATENT_MAX_DEF = 64;

   localparam int ACTION_W = 2;
   localparam int ROW_W    = 12;
   localparam int ELEM_W   = 6;
   localparam int VALUE_W  = 16;
   localparam int PRED_W   = 40;
   localparam int LIU_W    = 7;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE_USER = 2'd0,
      ACT_WRITE_ITEM = 2'd1,
      ACT_IMAGE      = 2'd2,
      ACT_RATE       = 2'd3
   } action_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WEIGHT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE_WEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIAS_ENABLE   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GLOBAL_BIAS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LATENT_IN_USE = 3'd4;

   localparam logic signed [15:0] IMAGE_WEIGHT_RST  = 16'sd256;
   localparam logic signed [15:0] TABLE_WEIGHT_RST  = 16'sd256;
   localparam logic [LIU_W-1:0]   LATENT_IN_USE_RST = 7'd64;

endpackage

// File: design/lfrp_ram.sv
module lfrp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: design/latent_factor_rating_predictor.sv
// table write beats are written on the accepting beat and never raise busy
// image feature beats go through an item table read, then mix and write of the mixed vector
// rate beats read n elements, n = min(latent_in_use, LATENT_MAX), and go straight to drain when n is zero:
// one user/mixed read per cycle and a two-stage multiply-accumulate behind the memory read
// the receiver cannot stall; reset restores control and configuration, table contents stay undefined
module latent_factor_rating_predictor #(
   parameter int USER_COUNT = lfrp_pkg::USER_COUNT_DEF,
   parameter int ITEM_COUNT = lfrp_pkg::ITEM_COUNT_DEF,
   parameter int LATENT_MAX = lfrp_pkg::LATENT_MAX_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  lfrp_pkg::action_type                req_action,
   input  logic [lfrp_pkg::ROW_W-1:0]          req_row_index,
   input  logic [lfrp_pkg::ELEM_W-1:0]         req_element_index,
   input  logic signed [lfrp_pkg::VALUE_W-1:0] req_value,
   input  logic [lfrp_pkg::ROW_W-1:0]          req_item_id,
   output logic                                rsp_valid,
   output logic signed [lfrp_pkg::PRED_W-1:0]  rsp_prediction,
   output logic [lfrp_pkg::ROW_W-1:0]          rsp_rated_user,
   input  logic                                csr_write_en,
   input  logic [lfrp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lfrp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int UADDR_W = (USER_COUNT * LATENT_MAX > 1) ? $clog2(USER_COUNT * LATENT_MAX) : 1;
   localparam int IADDR_W = (ITEM_COUNT * LATENT_MAX > 1) ? $clog2(ITEM_COUNT * LATENT_MAX) : 1;
   localparam int MIX_W   = (LATENT_MAX > 1) ? $clog2(LATENT_MAX) : 1;
   localparam int CNT_W   = $clog2(LATENT_MAX + 1);
   localparam int SUM_RAW = $clog2(LATENT_MAX) + 33;
   localparam int SUM_W   = (SUM_RAW > lfrp_pkg::PRED_W + 1) ? SUM_RAW : lfrp_pkg::PRED_W + 1;
   localparam int VW      = lfrp_pkg::VALUE_W;
   localparam int PW      = lfrp_pkg::PRED_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // configuration
   logic signed [15:0]              image_weight_ff, image_weight_in;
   logic signed [15:0]              table_weight_ff, table_weight_in;
   logic                            bias_enable_ff, bias_enable_in;
   logic signed [31:0]              global_bias_ff, global_bias_in;
   logic [lfrp_pkg::LIU_W-1:0]      latent_in_use_ff, latent_in_use_in;

   // control
   state_type                       state_ff, state_in;
   logic [CNT_W-1:0]                k_ff, k_in;
   logic [CNT_W-1:0]                n_ff, n_in;
   logic                            rd_valid_ff, rd_valid_in;
   logic                            prod_valid_ff, prod_valid_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // payload
   logic [UADDR_W-1:0]              base_ff, base_in;
   logic [lfrp_pkg::ROW_W-1:0]      user_ff, user_in;
   logic [MIX_W-1:0]                mix_addr_ff, mix_addr_in;
   logic signed [31:0]              img_prod_ff, img_prod_in;
   logic signed [31:0]              prod_ff, prod_in;
   logic signed [SUM_W-1:0]         acc_ff, acc_in;
   logic signed [PW-1:0]            pred_ff, pred_in;
   logic [lfrp_pkg::ROW_W-1:0]      rated_ff, rated_in;

   logic                            accept;
   logic                            row_user_ok, row_item_ok, item_ok, elem_ok;
   logic [31:0]                     user_base_full, item_addr_full, n_full;

   logic                            user_wr_en, item_wr_en, mix_wr_en;
   logic [UADDR_W-1:0]              user_wr_addr, user_rd_addr;
   logic [IADDR_W-1:0]              item_wr_addr, item_rd_addr;
   logic                            item_rd_en, run_rd_en;
   logic [VW-1:0]                   user_rdata, item_rdata, mix_rdata, mix_wdata;

   logic signed [31:0]              tbl_prod;
   logic signed [32:0]              mix_sum;
   logic signed [24:0]              mix_shift;
   logic signed [SUM_W-1:0]         final_sum;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   assign row_user_ok = (32'(req_row_index) < 32'(USER_COUNT));
   assign row_item_ok = (32'(req_row_index) < 32'(ITEM_COUNT));
   assign item_ok     = (32'(req_item_id) < 32'(ITEM_COUNT));
   assign elem_ok     = (32'(req_element_index) < 32'(LATENT_MAX));

   assign user_base_full = 32'(req_row_index) * 32'(LATENT_MAX);
   assign item_addr_full = (req_action == lfrp_pkg::ACT_IMAGE)
                           ? 32'(req_item_id) * 32'(LATENT_MAX) + 32'(req_element_index)
                           : 32'(req_row_index) * 32'(LATENT_MAX) + 32'(req_element_index);
   assign n_full = (32'(latent_in_use_ff) > 32'(LATENT_MAX))
                   ? 32'(LATENT_MAX) : 32'(latent_in_use_ff);

   // table writes go straight in on the accepting beat
   assign user_wr_en   = accept && (req_action == lfrp_pkg::ACT_WRITE_USER) && row_user_ok && elem_ok;
   assign user_wr_addr = UADDR_W'(user_base_full + 32'(req_element_index));
   assign item_wr_en   = accept && (req_action == lfrp_pkg::ACT_WRITE_ITEM) && row_item_ok && elem_ok;
   assign item_wr_addr = IADDR_W'(item_addr_full);
   assign item_rd_en   = accept && (req_action == lfrp_pkg::ACT_IMAGE) && item_ok && elem_ok;
   assign item_rd_addr = IADDR_W'(item_addr_full);

   assign run_rd_en    = (state_ff == ST_RUN);
   assign user_rd_addr = base_ff + UADDR_W'(k_ff);

   // mix stage: image product was registered on accept
   assign tbl_prod  = 32'(table_weight_ff) * 32'($signed(item_rdata));
   assign mix_sum   = 33'(img_prod_ff) + 33'(tbl_prod);
   assign mix_shift = mix_sum[32:8];
   assign mix_wr_en = (state_ff == ST_MIX);
   always_comb begin
      if (mix_shift[24:15] == {10{mix_shift[24]}}) begin
         mix_wdata = mix_shift[15:0];
      end else if (mix_shift[24]) begin
         mix_wdata = 16'h8000;
      end else begin
         mix_wdata = 16'h7fff;
      end
   end

   assign final_sum = acc_ff + (bias_enable_ff ? SUM_W'(global_bias_ff) : '0);

   always_comb begin
      image_weight_in  = image_weight_ff;
      table_weight_in  = table_weight_ff;
      bias_enable_in   = bias_enable_ff;
      global_bias_in   = global_bias_ff;
      latent_in_use_in = latent_in_use_ff;
      state_in         = state_ff;
      k_in             = k_ff;
      n_in             = n_ff;
      rd_valid_in      = 1'b0;
      prod_valid_in    = rd_valid_ff;
      rsp_valid_in     = 1'b0;
      base_in          = base_ff;
      user_in          = user_ff;
      mix_addr_in      = mix_addr_ff;
      img_prod_in      = img_prod_ff;
      prod_in          = 32'($signed(user_rdata)) * 32'($signed(mix_rdata));
      acc_in           = prod_valid_ff ? acc_ff + SUM_W'(prod_ff) : acc_ff;
      pred_in          = pred_ff;
      rated_in         = rated_ff;

      if (csr_write_en) begin
         case (csr_index)
            lfrp_pkg::CSR_IMAGE_WEIGHT:  image_weight_in  = csr_wdata[15:0];
            lfrp_pkg::CSR_TABLE_WEIGHT:  table_weight_in  = csr_wdata[15:0];
            lfrp_pkg::CSR_BIAS_ENABLE:   bias_enable_in   = csr_wdata[0];
            lfrp_pkg::CSR_GLOBAL_BIAS:   global_bias_in   = csr_wdata[31:0];
            lfrp_pkg::CSR_LATENT_IN_USE: latent_in_use_in = csr_wdata[lfrp_pkg::LIU_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mix_addr_in = MIX_W'(32'(req_element_index));
               img_prod_in = 32'(image_weight_ff) * 32'(req_value);
               base_in     = UADDR_W'(user_base_full);
               user_in     = req_row_index;
               n_in        = CNT_W'(n_full);
               k_in        = '0;
               acc_in      = '0;
               if (item_rd_en) begin
                  state_in = ST_MIX;
               end else if (req_action == lfrp_pkg::ACT_RATE && row_user_ok) begin
                  state_in = (n_full == 32'd0) ? ST_DRAIN : ST_RUN;
               end
            end
         end
         ST_MIX: begin
            state_in = ST_IDLE;
         end
         ST_RUN: begin
            rd_valid_in = 1'b1;
            k_in        = k_ff + CNT_W'(1);
            if (k_ff + CNT_W'(1) == n_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the multiply-accumulate pipe to empty
            if (!rd_valid_ff && !prod_valid_ff) begin
               rsp_valid_in = 1'b1;
               rated_in     = user_ff;
               if (final_sum[SUM_W-1:PW-1] == {(SUM_W-PW+1){final_sum[SUM_W-1]}}) begin
                  pred_in = final_sum[PW-1:0];
               end else if (final_sum[SUM_W-1]) begin
                  pred_in = {1'b1, {(PW-1){1'b0}}};
               end else begin
                  pred_in = {1'b0, {(PW-1){1'b1}}};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_weight_ff  <= lfrp_pkg::IMAGE_WEIGHT_RST;
         table_weight_ff  <= lfrp_pkg::TABLE_WEIGHT_RST;
         bias_enable_ff   <= 1'b0;
         global_bias_ff   <= '0;
         latent_in_use_ff <= lfrp_pkg::LATENT_IN_USE_RST;
         state_ff         <= ST_IDLE;
         k_ff             <= '0;
         n_ff             <= '0;
         rd_valid_ff      <= 1'b0;
         prod_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         image_weight_ff  <= image_weight_in;
         table_weight_ff  <= table_weight_in;
         bias_enable_ff   <= bias_enable_in;
         global_bias_ff   <= global_bias_in;
         latent_in_use_ff <= latent_in_use_in;
         state_ff         <= state_in;
         k_ff             <= k_in;
         n_ff             <= n_in;
         rd_valid_ff      <= rd_valid_in;
         prod_valid_ff    <= prod_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      base_ff     <= base_in;
      user_ff     <= user_in;
      mix_addr_ff <= mix_addr_in;
      img_prod_ff <= img_prod_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      pred_ff     <= pred_in;
      rated_ff    <= rated_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prediction = pred_ff;
   assign rsp_rated_user = rated_ff;

   lfrp_ram #(.WIDTH(VW), .DEPTH(USER_COUNT * LATENT_MAX)) u_user_ram (
      .clock   (clock),
      .wr_en   (user_wr_en),
      .wr_addr (user_wr_addr),
      .wr_data (req_value),
      .rd_en   (run_rd_en),
      .rd_addr (user_rd_addr),
      .rd_data (user_rdata)
   );

   lfrp_ram #(.WIDTH(VW), .DEPTH(ITEM_COUNT * LATENT_MAX)) u_item_ram (
      .clock   (clock),
      .wr_en   (item_wr_en),
      .wr_addr (item_wr_addr),
      .wr_data (req_value),
      .rd_en   (item_rd_en),
      .rd_addr (item_rd_addr),
      .rd_data (item_rdata)
   );

   lfrp_ram #(.WIDTH(VW), .DEPTH(LATENT_MAX)) u_mix_ram (
      .clock   (clock),
      .wr_en   (mix_wr_en),
      .wr_addr (mix_addr_ff),
      .wr_data (mix_wdata),
      .rd_en   (run_rd_en),
      .rd_addr (k_ff[MIX_W-1:0]),
      .rd_data (mix_rdata)
   );

endmodule
